// ===== rtl/bpfs_pkg.sv =====
// Shared types and constants of the Blinn-Phong fragment shader.
package bpfs_pkg;

    // Port field widths.
    localparam int FIELD_W = 16;
    localparam int CHAN_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHININESS = 3'd5;

    // Vector formats: raw vectors fit in 17 signed bits, unit vectors are Q2.14.
    localparam int VEC_W = 17;
    localparam int UNIT_W = 16;
    localparam int QUOT_BITS = 15;
    localparam int DOT_W = 15;
    localparam int Q14_ONE = 16384;

    // Normalizer pipeline depth is COORD_BITS plus this many stages.
    localparam int NORM_EXTRA_STAGES = 4 + QUOT_BITS;
    localparam int POW_LAT = 5;
    localparam int SHADE_LAT = 4;

    // Division by 255 as a multiply by a reciprocal, exact below 2^18.
    localparam int RECIP_255 = 263173;
    localparam int RECIP_SHIFT = 26;

    typedef struct packed {
        logic [47:0] light_pos;
        logic [23:0] light_color;
        logic [23:0] ambient;
        logic [23:0] diffuse;
        logic [23:0] specular;
        logic [15:0] shininess;
    } cfg_t;

endpackage

// ===== rtl/bpfs_if.sv =====
// Request channel interfaces for fragments in and colors out.
interface bpfs_frag_if;
    logic valid;
    logic ready;
    logic signed [bpfs_pkg::FIELD_W-1:0] pos_x;
    logic signed [bpfs_pkg::FIELD_W-1:0] pos_y;
    logic signed [bpfs_pkg::FIELD_W-1:0] pos_z;
    logic signed [bpfs_pkg::FIELD_W-1:0] norm_x;
    logic signed [bpfs_pkg::FIELD_W-1:0] norm_y;
    logic signed [bpfs_pkg::FIELD_W-1:0] norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  output ready);
endinterface

interface bpfs_rgb_if;
    logic valid;
    logic ready;
    logic [bpfs_pkg::CHAN_W-1:0] red;
    logic [bpfs_pkg::CHAN_W-1:0] green;
    logic [bpfs_pkg::CHAN_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/bpfs_norm.sv =====
// Pipelined 3-vector normalizer: range scaling, square root and division stages.
module bpfs_norm #(
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [bpfs_pkg::VEC_W-1:0] in_vec [3],
    output logic out_valid,
    output logic signed [bpfs_pkg::UNIT_W-1:0] out_vec [3]
);
    localparam int MAG_W = bpfs_pkg::VEC_W;
    localparam int SC_W = COORD_BITS - 1;
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int RT_W = COORD_BITS;
    localparam int QB = bpfs_pkg::QUOT_BITS;
    localparam int DV_W = COORD_BITS + QB;
    localparam int TW = $clog2(MAG_W);
    localparam int WIDE_W = MAG_W + COORD_BITS - 2;

    // Stage 1: magnitudes, signs and largest magnitude.
    logic [MAG_W-1:0] mag_c [3];
    logic [MAG_W-1:0] mx_c;
    logic s1_v_reg;
    logic [MAG_W-1:0] s1_mag_reg [3];
    logic [2:0] s1_sgn_reg;
    logic [MAG_W-1:0] s1_mx_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_c[k] = in_vec[k][MAG_W-1] ? MAG_W'(-in_vec[k]) : MAG_W'(in_vec[k]);
        end
        mx_c = mag_c[0];
        if (mag_c[1] > mx_c)
        begin
            mx_c = mag_c[1];
        end
        if (mag_c[2] > mx_c)
        begin
            mx_c = mag_c[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_mag_reg[k] <= mag_c[k];
                s1_sgn_reg[k] <= in_vec[k][MAG_W-1];
            end
            s1_mx_reg <= mx_c;
        end
    end

    // Stage 2: scale so the largest magnitude has its top bit at COORD_BITS-2.
    logic [TW-1:0] top_c;
    logic [WIDE_W-1:0] wide_c [3];
    logic s2_v_reg;
    logic [SC_W-1:0] s2_mag_reg [3];
    logic [2:0] s2_sgn_reg;

    always_comb
    begin
        top_c = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (s1_mx_reg[i])
            begin
                top_c = TW'(i);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            wide_c[k] = {s1_mag_reg[k], {(COORD_BITS-2){1'b0}}} >> top_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_mag_reg[k] <= wide_c[k][SC_W-1:0];
            end
            s2_sgn_reg <= s1_sgn_reg;
        end
    end

    // Stage 3: squares.
    logic s3_v_reg;
    logic [2*SC_W-1:0] s3_sq_reg [3];
    logic [SC_W-1:0] s3_mag_reg [3];
    logic [2:0] s3_sgn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_sq_reg[k] <= (2*SC_W)'(s2_mag_reg[k]) * (2*SC_W)'(s2_mag_reg[k]);
                s3_mag_reg[k] <= s2_mag_reg[k];
            end
            s3_sgn_reg <= s2_sgn_reg;
        end
    end

    // Stage 4 and square root stages, one root bit per stage.
    logic sq_v_reg [RT_W+1];
    logic [SQ_W-1:0] sq_rem_reg [RT_W+1];
    logic [RT_W-1:0] sq_root_reg [RT_W+1];
    logic [SC_W-1:0] sq_mag_reg [RT_W+1][3];
    logic [2:0] sq_sgn_reg [RT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0] <= SQ_W'(s3_sq_reg[0]) + SQ_W'(s3_sq_reg[1]) + SQ_W'(s3_sq_reg[2]);
            sq_root_reg[0] <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sq_mag_reg[0][k] <= s3_mag_reg[k];
            end
            sq_sgn_reg[0] <= s3_sgn_reg;
        end
    end

    for (genvar j = 0; j < RT_W; j++)
    begin : g_sqrt
        localparam int B = RT_W - 1 - j;
        logic [SQ_W:0] trial;
        logic fits;

        assign trial = ((SQ_W+1)'(sq_root_reg[j]) << (B + 1)) + ((SQ_W+1)'(1) << (2 * B));
        assign fits = {1'b0, sq_rem_reg[j]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[j+1] <= sq_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[j+1] <= fits ? sq_rem_reg[j] - trial[SQ_W-1:0] : sq_rem_reg[j];
                sq_root_reg[j+1] <= fits ? (sq_root_reg[j] | (RT_W'(1) << B))
                                         : sq_root_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    sq_mag_reg[j+1][k] <= sq_mag_reg[j][k];
                end
                sq_sgn_reg[j+1] <= sq_sgn_reg[j];
            end
        end
    end

    // Division stages, one quotient bit per stage and lane.
    logic dv_v [QB+1];
    logic [DV_W-1:0] dv_rem [QB+1][3];
    logic [QB-1:0] dv_q [QB+1][3];
    logic [RT_W-1:0] dv_len [QB+1];
    logic [2:0] dv_sgn [QB+1];

    assign dv_v[0] = sq_v_reg[RT_W];
    assign dv_len[0] = sq_root_reg[RT_W];
    assign dv_sgn[0] = sq_sgn_reg[RT_W];
    for (genvar k = 0; k < 3; k++)
    begin : g_dv_in
        assign dv_rem[0][k] = DV_W'(sq_mag_reg[RT_W][k]) << (QB - 1);
        assign dv_q[0][k] = '0;
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int B = QB - 1 - j;
        logic [DV_W-1:0] dvs;

        assign dvs = DV_W'(dv_len[j]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v[j+1] <= dv_v[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (dv_rem[j][k] >= dvs)
                    begin
                        dv_rem[j+1][k] <= dv_rem[j][k] - dvs;
                        dv_q[j+1][k] <= dv_q[j][k] | (QB'(1) << B);
                    end
                    else
                    begin
                        dv_rem[j+1][k] <= dv_rem[j][k];
                        dv_q[j+1][k] <= dv_q[j][k];
                    end
                end
                dv_len[j+1] <= dv_len[j];
                dv_sgn[j+1] <= dv_sgn[j];
            end
        end
    end

    // A zero-length vector comes out as the zero vector.
    assign out_valid = dv_v[QB];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dv_len[QB] == '0)
            begin
                out_vec[k] = '0;
            end
            else if (dv_sgn[QB][k])
            begin
                out_vec[k] = -$signed({1'b0, dv_q[QB][k]});
            end
            else
            begin
                out_vec[k] = $signed({1'b0, dv_q[QB][k]});
            end
        end
    end

endmodule

// ===== rtl/bpfs_pow.sv =====
// Pipelined specular power unit: N.H raised to the shininess via log2 and exp2 tables.
module bpfs_pow #(
    parameter int POW_TABLE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [bpfs_pkg::DOT_W-1:0] d,
    input  logic [15:0] shin,
    output logic out_valid,
    output logic [bpfs_pkg::DOT_W-1:0] pw
);
    localparam int IDX_W = $clog2(POW_TABLE_DEPTH);

    // log2(y / 2^30) in Q.16 for y in [2^30, 2^31), by repeated squaring.
    function automatic logic [15:0] log_frac(logic [63:0] y_in);
        logic [63:0] y;
        logic [15:0] r;
        y = y_in;
        r = '0;
        for (int k = 0; k < 16; k++)
        begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= 64'h8000_0000)
            begin
                r[0] = 1'b1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    // Inverse of the log routine by binary search over the mantissa.
    function automatic logic [16:0] exp_entry(logic [31:0] g);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        lo = '0;
        hi = 32'd65535;
        for (int k = 0; k < 17; k++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 32'd1) >> 1;
                if (32'(log_frac(64'h4000_0000 + (64'(mid) << 14))) <= g)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 32'd1;
                end
            end
        end
        return 17'((32'd65536 + lo) >> 1);
    endfunction

    // Constant tables.
    logic [15:0] log_rom [POW_TABLE_DEPTH];
    logic [16:0] exp_rom [POW_TABLE_DEPTH];

    for (genvar i = 0; i < POW_TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] LY = 64'h4000_0000 + ((64'(i) << 30) / POW_TABLE_DEPTH);
        localparam logic [15:0] LV = log_frac(LY);
        localparam logic [31:0] G = 32'd65536 - 32'((64'(i) << 16) / POW_TABLE_DEPTH);
        localparam logic [16:0] EV = (i == 0) ? 17'd65536 : exp_entry(G);
        assign log_rom[i] = LV;
        assign exp_rom[i] = EV;
    end

    // Stage 1: exponent and mantissa index of N.H.
    logic [3:0] e_c;
    logic [14:0] sh_c;
    logic [31:0] idx_prod_c;
    logic p1_v_reg;
    logic p1_zd_reg;
    logic p1_zs_reg;
    logic [3:0] p1_e_reg;
    logic [IDX_W-1:0] p1_idx_reg;

    always_comb
    begin
        e_c = '0;
        for (int i = 0; i < 15; i++)
        begin
            if (d[i])
            begin
                e_c = 4'(i);
            end
        end
        sh_c = d << (4'd14 - e_c);
        idx_prod_c = (32'(sh_c[13:0]) * POW_TABLE_DEPTH) >> 14;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_zd_reg <= (d == '0);
            p1_zs_reg <= (shin == '0);
            p1_e_reg <= e_c;
            p1_idx_reg <= idx_prod_c[IDX_W-1:0];
        end
    end

    // Stage 2: negated log in Q.16.
    logic p2_v_reg;
    logic p2_zd_reg;
    logic p2_zs_reg;
    logic [19:0] p2_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_zd_reg <= p1_zd_reg;
            p2_zs_reg <= p1_zs_reg;
            p2_neg_reg <= (20'(4'd14 - p1_e_reg) << 16) - 20'(log_rom[p1_idx_reg]);
        end
    end

    // Stage 3: scale by the shininess.
    logic [35:0] prod_c;
    logic p3_v_reg;
    logic p3_zd_reg;
    logic p3_zs_reg;
    logic [27:0] p3_p_reg;

    assign prod_c = 36'(p2_neg_reg) * 36'(shin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_zd_reg <= p2_zd_reg;
            p3_zs_reg <= p2_zs_reg;
            p3_p_reg <= prod_c[35:8];
        end
    end

    // Stage 4: integer shift and exp2 table index.
    logic [31:0] j_prod_c;
    logic p4_v_reg;
    logic p4_zd_reg;
    logic p4_zs_reg;
    logic p4_big_reg;
    logic [3:0] p4_q_reg;
    logic [IDX_W-1:0] p4_j_reg;

    assign j_prod_c = (32'(p3_p_reg[15:0]) * POW_TABLE_DEPTH) >> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_zd_reg <= p3_zd_reg;
            p4_zs_reg <= p3_zs_reg;
            p4_big_reg <= (p3_p_reg[27:16] >= 12'd15);
            p4_q_reg <= p3_p_reg[19:16];
            p4_j_reg <= j_prod_c[IDX_W-1:0];
        end
    end

    // Stage 5: exp2 lookup and final shift, with the special cases.
    logic [16:0] ex_c;
    logic p5_v_reg;
    logic [bpfs_pkg::DOT_W-1:0] p5_pw_reg;

    assign ex_c = (exp_rom[p4_j_reg] >> 2) >> p4_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p5_v_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (p4_zs_reg)
            begin
                p5_pw_reg <= bpfs_pkg::DOT_W'(bpfs_pkg::Q14_ONE);
            end
            else if (p4_zd_reg || p4_big_reg)
            begin
                p5_pw_reg <= '0;
            end
            else
            begin
                p5_pw_reg <= ex_c[bpfs_pkg::DOT_W-1:0];
            end
        end
    end

    assign out_valid = p5_v_reg;
    assign pw = p5_pw_reg;

endmodule

// ===== rtl/bpfs_shade.sv =====
// Pipelined color combine: ambient, diffuse and specular terms times light color.
module bpfs_shade (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [bpfs_pkg::DOT_W-1:0] nl,
    input  logic [bpfs_pkg::DOT_W-1:0] pw,
    input  bpfs_pkg::cfg_t cfg,
    output logic out_valid,
    output logic [bpfs_pkg::CHAN_W-1:0] red,
    output logic [bpfs_pkg::CHAN_W-1:0] green,
    output logic [bpfs_pkg::CHAN_W-1:0] blue
);
    localparam int PW = 23;
    localparam int YW = 37;

    // Channel 0 is red in the top byte of each color register.
    function automatic logic [7:0] chan(logic [23:0] c, int k);
        return c[23 - 8 * k -: 8];
    endfunction

    // Stage 1: diffuse and specular products.
    logic s1_v_reg;
    logic [PW-1:0] s1_dn_reg [3];
    logic [PW-1:0] s1_sp_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_dn_reg[k] <= PW'(chan(cfg.diffuse, k)) * PW'(nl);
                s1_sp_reg[k] <= PW'(chan(cfg.specular, k)) * PW'(pw);
            end
        end
    end

    // Stage 2: rounded sum of the three terms.
    logic s2_v_reg;
    logic [9:0] s2_sum_reg [3];
    logic [PW:0] dr_c [3];
    logic [PW:0] sr_c [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dr_c[k] = ((PW+1)'(s1_dn_reg[k]) + (PW+1)'(8192)) >> 14;
            sr_c[k] = ((PW+1)'(s1_sp_reg[k]) + (PW+1)'(8192)) >> 14;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_sum_reg[k] <= 10'(chan(cfg.ambient, k)) + dr_c[k][9:0] + sr_c[k][9:0];
            end
        end
    end

    // Stage 3: light color product with rounding bias.
    logic s3_v_reg;
    logic [17:0] s3_x_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_x_reg[k] <= 18'(s2_sum_reg[k]) * 18'(chan(cfg.light_color, k)) + 18'd127;
            end
        end
    end

    // Stage 4: divide by 255 through the reciprocal.
    logic s4_v_reg;
    logic [YW-1:0] s4_y_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s4_y_reg[k] <= YW'(s3_x_reg[k]) * YW'(bpfs_pkg::RECIP_255);
            end
        end
    end

    // Saturate to 8 bits.
    logic [7:0] c_c [3];
    logic [YW-1:0] q_c [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q_c[k] = s4_y_reg[k] >> bpfs_pkg::RECIP_SHIFT;
            c_c[k] = (q_c[k] > YW'(255)) ? 8'd255 : q_c[k][7:0];
        end
    end

    assign out_valid = s4_v_reg;
    assign red = c_c[0];
    assign green = c_c[1];
    assign blue = c_c[2];

endmodule

// ===== rtl/blinn_phong_fragment_shade_top.sv =====
// Top level of the pipelined Blinn-Phong fragment shader.
//
//  Channel   Direction  Handshake      Payload
//  frag      in         valid/ready    pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
//  rgb       out        valid/ready    red, green, blue
//  cfg       in         cfg_we         cfg_index, cfg_wdata (no wait, no read-back)
//
// One fragment is accepted per cycle while ready is high; the path from acceptance to
// the result on rgb runs through the two chained normalizers (square root
// and division stages) followed by the dot, power and color stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled result sits in the output register while the pipeline keeps moving into
// a one-entry skid buffer; only a full skid buffer freezes the pipeline and drops ready.
module blinn_phong_fragment_shade_top #(
    parameter int COORD_BITS = 16,
    parameter int POW_TABLE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    bpfs_frag_if.sink frag,
    bpfs_rgb_if.source rgb,
    input  logic cfg_we,
    input  logic [bpfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    localparam int VW = bpfs_pkg::VEC_W;
    localparam int UW = bpfs_pkg::UNIT_W;
    localparam int DW = bpfs_pkg::DOT_W;
    localparam int LAT_N = COORD_BITS + bpfs_pkg::NORM_EXTRA_STAGES;
    localparam int LAT_P = bpfs_pkg::POW_LAT;

    logic en;
    logic skid_v_reg;

    assign en = !skid_v_reg;
    assign frag.ready = en;

    // Configuration registers.
    bpfs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_pos <= '0;
            cfg_reg.light_color <= 24'hFFFFFF;
            cfg_reg.ambient <= '0;
            cfg_reg.diffuse <= 24'hFFFFFF;
            cfg_reg.specular <= 24'hFFFFFF;
            cfg_reg.shininess <= 16'd8192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpfs_pkg::REG_LIGHT_POS:   cfg_reg.light_pos <= cfg_wdata;
                bpfs_pkg::REG_LIGHT_COLOR: cfg_reg.light_color <= cfg_wdata[23:0];
                bpfs_pkg::REG_AMBIENT:     cfg_reg.ambient <= cfg_wdata[23:0];
                bpfs_pkg::REG_DIFFUSE:     cfg_reg.diffuse <= cfg_wdata[23:0];
                bpfs_pkg::REG_SPECULAR:    cfg_reg.specular <= cfg_wdata[23:0];
                bpfs_pkg::REG_SHININESS:   cfg_reg.shininess <= cfg_wdata[15:0];
                default:                   ;
            endcase
        end
    end

    // Input stage.
    logic t0_v_reg;
    logic signed [15:0] t0_p_reg [3];
    logic signed [15:0] t0_n_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t0_v_reg <= frag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_p_reg[0] <= frag.pos_x;
            t0_p_reg[1] <= frag.pos_y;
            t0_p_reg[2] <= frag.pos_z;
            t0_n_reg[0] <= frag.norm_x;
            t0_n_reg[1] <= frag.norm_y;
            t0_n_reg[2] <= frag.norm_z;
        end
    end

    // Raw normal, view and light vectors.
    logic signed [VW-1:0] nvec [3];
    logic signed [VW-1:0] vvec [3];
    logic signed [VW-1:0] lvec [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nvec[k] = VW'(t0_n_reg[k]);
            vvec[k] = -VW'(t0_p_reg[k]);
            lvec[k] = VW'($signed(cfg_reg.light_pos[16*k+15 -: 16])) - VW'(t0_p_reg[k]);
        end
    end

    logic n_v;
    logic v_v;
    logic l_v;
    logic signed [UW-1:0] n_u [3];
    logic signed [UW-1:0] v_u [3];
    logic signed [UW-1:0] l_u [3];

    bpfs_norm #(.COORD_BITS(COORD_BITS)) u_norm_n (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_reg), .in_vec(nvec),
        .out_valid(n_v), .out_vec(n_u)
    );

    bpfs_norm #(.COORD_BITS(COORD_BITS)) u_norm_v (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_reg), .in_vec(vvec),
        .out_valid(v_v), .out_vec(v_u)
    );

    bpfs_norm #(.COORD_BITS(COORD_BITS)) u_norm_l (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_reg), .in_vec(lvec),
        .out_valid(l_v), .out_vec(l_u)
    );

    // Half vector sum; normal and light held for the dot products.
    logic t1_v_reg;
    logic signed [VW-1:0] t1_h_reg [3];
    logic [5:0][UW-1:0] t1_nl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_v_reg <= n_v & v_v & l_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t1_h_reg[k] <= VW'(l_u[k]) + VW'(v_u[k]);
                t1_nl_reg[k] <= n_u[k];
                t1_nl_reg[3+k] <= l_u[k];
            end
        end
    end

    logic h_v;
    logic signed [UW-1:0] h_u [3];

    bpfs_norm #(.COORD_BITS(COORD_BITS)) u_norm_h (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t1_v_reg), .in_vec(t1_h_reg),
        .out_valid(h_v), .out_vec(h_u)
    );

    // Delay line for the normal and light unit vectors.
    logic [5:0][UW-1:0] nl_dly_reg [LAT_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nl_dly_reg[0] <= t1_nl_reg;
            for (int i = 1; i < LAT_N; i++)
            begin
                nl_dly_reg[i] <= nl_dly_reg[i-1];
            end
        end
    end

    // Dot product terms.
    logic t2_v_reg;
    logic signed [31:0] t2_nh_reg [3];
    logic signed [31:0] t2_nl_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t2_v_reg <= h_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t2_nh_reg[k] <= $signed(nl_dly_reg[LAT_N-1][k]) * h_u[k];
                t2_nl_reg[k] <= $signed(nl_dly_reg[LAT_N-1][k]) * $signed(nl_dly_reg[LAT_N-1][3+k]);
            end
        end
    end

    // Clamp a Q.28 dot sum to [0, 1.0] in Q.14.
    function automatic logic [DW-1:0] dot_clamp(logic signed [33:0] s);
        logic signed [33:0] r;
        r = s >>> 14;
        if (s <= 0)
        begin
            return '0;
        end
        else if (r > 34'sd16384)
        begin
            return DW'(bpfs_pkg::Q14_ONE);
        end
        return r[DW-1:0];
    endfunction

    logic t3_v_reg;
    logic [DW-1:0] t3_nl_reg;
    logic [DW-1:0] t3_nh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t3_v_reg <= t2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_nl_reg <= dot_clamp(34'(t2_nl_reg[0]) + 34'(t2_nl_reg[1]) + 34'(t2_nl_reg[2]));
            t3_nh_reg <= dot_clamp(34'(t2_nh_reg[0]) + 34'(t2_nh_reg[1]) + 34'(t2_nh_reg[2]));
        end
    end

    // Specular power, with N.L delayed alongside.
    logic p_v;
    logic [DW-1:0] pw;
    logic [DW-1:0] nlp_dly_reg [LAT_P];

    bpfs_pow #(.POW_TABLE_DEPTH(POW_TABLE_DEPTH)) u_pow (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t3_v_reg), .d(t3_nh_reg),
        .shin(cfg_reg.shininess), .out_valid(p_v), .pw(pw)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nlp_dly_reg[0] <= t3_nl_reg;
            for (int i = 1; i < LAT_P; i++)
            begin
                nlp_dly_reg[i] <= nlp_dly_reg[i-1];
            end
        end
    end

    // Color combine.
    logic fin_v;
    logic [7:0] fin_r;
    logic [7:0] fin_g;
    logic [7:0] fin_b;

    bpfs_shade u_shade (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(p_v), .nl(nlp_dly_reg[LAT_P-1]),
        .pw(pw), .cfg(cfg_reg), .out_valid(fin_v), .red(fin_r), .green(fin_g),
        .blue(fin_b)
    );

    // Output register and skid buffer.
    logic out_v_reg;
    logic [23:0] out_reg;
    logic [23:0] skid_reg;
    logic take;

    assign take = out_v_reg & rgb.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (take)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (out_v_reg && !take)
        begin
            skid_v_reg <= fin_v;
        end
        else
        begin
            out_v_reg <= fin_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_v_reg && !take)
        begin
            skid_reg <= {fin_r, fin_g, fin_b};
        end
        else
        begin
            out_reg <= {fin_r, fin_g, fin_b};
        end
    end

    assign rgb.valid = out_v_reg;
    assign rgb.red = out_reg[23:16];
    assign rgb.green = out_reg[15:8];
    assign rgb.blue = out_reg[7:0];

endmodule
